>>> rtl/core/edist_pkg.sv
// shared constants, types and helpers for the edit distance engine
package edist_pkg;

    localparam int MAX_LEN  = 64;
    localparam int LEN_W    = $clog2(MAX_LEN + 1);
    localparam int ADDR_W   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int SYM_W    = 8;
    localparam int REQ_W    = 2;
    localparam int DIST_W   = 7;
    localparam int DIST_MAX = 127;

    localparam logic [REQ_W-1:0] REQ_FIRST   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_SECOND  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_COMPUTE = 2'd2;

    typedef logic [LEN_W-1:0] t_len;

    typedef struct packed {
        logic app_first;
        logic app_second;
        logic begin_calc;
        logic init_wr;
        logic cell_upd;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic any_empty;
        logic j_last;
        logic i_last;
    } t_dp_stat;

    function automatic logic [DIST_W-1:0] sat_dist(input t_len x);
        logic [31:0] v;
        v = 32'(x);
        return (v > 32'(DIST_MAX)) ? DIST_W'(DIST_MAX) : DIST_W'(v);
    endfunction

endpackage

>>> rtl/core/edit_distance_engine.sv
// top level of the levenshtein edit distance engine
// A word is taken when start is high and busy is low. Appending a character
// to either string leaves busy low, so characters stream in back to back.
// A compute word raises busy; o_done then pulses for one cycle with the
// distance and overflow flag. Before that, the INIT state fills the cost row
// memory and each cell of the m by n table (m and n the lengths of the first
// and second string) passes through ST_CELL_A, for the registered reads of
// the cost row and both strings, and ST_CELL_B, where it is written; if either
// string is empty the engine goes straight to the result.
// Both strings and the overflow flag are cleared as the result is shown. There
// is no back-pressure: the result must be taken when o_done is high.
// Characters beyond 64 per string are dropped and set the overflow flag.
module edit_distance_engine
    import edist_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [REQ_W-1:0]   i_req_type,
    input  logic [SYM_W-1:0]   i_symbol,
    output logic               o_done,
    output logic [DIST_W-1:0]  o_distance,
    output logic               o_overflow
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    edist_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_req_type (i_req_type),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .busy       (busy),
        .o_done     (o_done)
    );

    edist_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_symbol   (i_symbol),
        .o_stat     (stat),
        .o_distance (o_distance),
        .o_overflow (o_overflow)
    );

`ifndef NO_ASSERTIONS
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> busy)
        else $error("result shown while not busy");

    a_done_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !busy && !o_done)
        else $error("engine did not return to idle after result");

    a_compute_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_req_type == REQ_COMPUTE) |=> busy)
        else $error("compute word did not start the sweep");

    a_append_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_req_type != REQ_COMPUTE) |=> !busy && !o_done)
        else $error("append word disturbed the controller");
`endif

endmodule

>>> rtl/core/edist_ram.sv
// generic simple dual-port ram with registered read
module edist_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                          i_clk,
    input  logic                                          i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  i_wr_addr,
    input  logic [WIDTH-1:0]                              i_wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  i_rd_addr,
    output logic [WIDTH-1:0]                              o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/core/edist_dp.sv
// datapath: string stores, cost row store, counters and cell update
module edist_dp
    import edist_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    input  logic [SYM_W-1:0]   i_symbol,
    output t_dp_stat           o_stat,
    output logic [DIST_W-1:0]  o_distance,
    output logic               o_overflow
);

    t_len r_first_len, n_first_len;
    t_len r_second_len, n_second_len;
    logic r_ovf, n_ovf;
    t_len r_i, n_i;
    t_len r_j, n_j;
    t_len r_diag, n_diag;
    t_len r_left, n_left;

    logic             first_full, second_full;
    logic             first_wr, second_wr;
    t_len             i_m1, j_m1;
    logic [SYM_W-1:0] first_rd, second_rd;
    t_len             above;
    t_len             min_a, min_b, cell_val;
    logic             cost_wr;
    t_len             cost_wdata;

    assign first_full  = (r_first_len == t_len'(MAX_LEN));
    assign second_full = (r_second_len == t_len'(MAX_LEN));
    assign first_wr    = i_cmd.app_first && !first_full;
    assign second_wr   = i_cmd.app_second && !second_full;

    assign i_m1 = r_i - t_len'(1);
    assign j_m1 = r_j - t_len'(1);

    edist_ram #(.WIDTH(SYM_W), .DEPTH(MAX_LEN)) u_first_ram (
        .i_clk     (i_clk),
        .i_wr_en   (first_wr),
        .i_wr_addr (r_first_len[ADDR_W-1:0]),
        .i_wr_data (i_symbol),
        .i_rd_addr (i_m1[ADDR_W-1:0]),
        .o_rd_data (first_rd)
    );

    edist_ram #(.WIDTH(SYM_W), .DEPTH(MAX_LEN)) u_second_ram (
        .i_clk     (i_clk),
        .i_wr_en   (second_wr),
        .i_wr_addr (r_second_len[ADDR_W-1:0]),
        .i_wr_data (i_symbol),
        .i_rd_addr (j_m1[ADDR_W-1:0]),
        .o_rd_data (second_rd)
    );

    // column j of the row lives at address j-1, column zero is implied by the row index
    edist_ram #(.WIDTH(LEN_W), .DEPTH(MAX_LEN)) u_cost_ram (
        .i_clk     (i_clk),
        .i_wr_en   (cost_wr),
        .i_wr_addr (j_m1[ADDR_W-1:0]),
        .i_wr_data (cost_wdata),
        .i_rd_addr (j_m1[ADDR_W-1:0]),
        .o_rd_data (above)
    );

    assign min_a    = (r_diag < above) ? r_diag : above;
    assign min_b    = (min_a < r_left) ? min_a : r_left;
    assign cell_val = (first_rd == second_rd) ? r_diag : (min_b + t_len'(1));

    assign cost_wr    = i_cmd.init_wr || i_cmd.cell_upd;
    assign cost_wdata = i_cmd.init_wr ? r_j : cell_val;

    assign o_stat.any_empty = (r_first_len == '0) || (r_second_len == '0);
    assign o_stat.j_last    = (r_j == r_second_len);
    assign o_stat.i_last    = (r_i == r_first_len);

    always_comb begin
        n_first_len  = r_first_len;
        n_second_len = r_second_len;
        n_ovf        = r_ovf;
        n_i          = r_i;
        n_j          = r_j;
        n_diag       = r_diag;
        n_left       = r_left;
        if (i_cmd.app_first) begin
            if (first_full) begin
                n_ovf = 1'b1;
            end else begin
                n_first_len = r_first_len + t_len'(1);
            end
        end
        if (i_cmd.app_second) begin
            if (second_full) begin
                n_ovf = 1'b1;
            end else begin
                n_second_len = r_second_len + t_len'(1);
            end
        end
        if (i_cmd.begin_calc) begin
            n_i    = t_len'(1);
            n_j    = t_len'(1);
            n_left = r_first_len | r_second_len;
        end
        if (i_cmd.init_wr) begin
            if (o_stat.j_last) begin
                n_j    = t_len'(1);
                n_diag = '0;
                n_left = t_len'(1);
            end else begin
                n_j = r_j + t_len'(1);
            end
        end
        if (i_cmd.cell_upd) begin
            if (o_stat.j_last && !o_stat.i_last) begin
                n_i    = r_i + t_len'(1);
                n_j    = t_len'(1);
                n_diag = r_i;
                n_left = r_i + t_len'(1);
            end else begin
                n_j    = r_j + t_len'(1);
                n_diag = above;
                n_left = cell_val;
            end
        end
        if (i_cmd.finish) begin
            n_first_len  = '0;
            n_second_len = '0;
            n_ovf        = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_len  <= '0;
            r_second_len <= '0;
            r_ovf        <= 1'b0;
        end else begin
            r_first_len  <= n_first_len;
            r_second_len <= n_second_len;
            r_ovf        <= n_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i    <= n_i;
        r_j    <= n_j;
        r_diag <= n_diag;
        r_left <= n_left;
    end

    assign o_distance = sat_dist(r_left);
    assign o_overflow = r_ovf;

endmodule

>>> rtl/core/edist_ctrl.sv
// controller state machine sequencing loads, row setup and the cell sweep
module edist_ctrl
    import edist_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  logic [REQ_W-1:0]  i_req_type,
    input  t_dp_stat          i_stat,
    output t_dp_cmd           o_cmd,
    output logic              busy,
    output logic              o_done
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_INIT   = 3'd1;
    localparam logic [2:0] ST_CELL_A = 3'd2;
    localparam logic [2:0] ST_CELL_B = 3'd3;
    localparam logic [2:0] ST_DONE   = 3'd4;

    logic [2:0] r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    case (i_req_type)
                        REQ_FIRST:  o_cmd.app_first  = 1'b1;
                        REQ_SECOND: o_cmd.app_second = 1'b1;
                        REQ_COMPUTE: begin
                            o_cmd.begin_calc = 1'b1;
                            n_state = i_stat.any_empty ? ST_DONE : ST_INIT;
                        end
                        default: ;
                    endcase
                end
            end
            ST_INIT: begin
                o_cmd.init_wr = 1'b1;
                if (i_stat.j_last) begin
                    n_state = ST_CELL_A;
                end
            end
            ST_CELL_A: begin
                n_state = ST_CELL_B;
            end
            ST_CELL_B: begin
                o_cmd.cell_upd = 1'b1;
                n_state = (i_stat.j_last && i_stat.i_last) ? ST_DONE : ST_CELL_A;
            end
            ST_DONE: begin
                o_cmd.finish = 1'b1;
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy   = (r_state != ST_IDLE);
    assign o_done = (r_state == ST_DONE);

endmodule
